// File: rtl/psd_pkg.sv
// shared types, constants and the arctangent table function for the principal stress block
package psd_pkg;

  localparam int RAD_W          = 66;
  localparam int CORDIC_STEPS   = 60;
  localparam int CORDIC_PRESHIFT = 26;
  localparam logic [63:0] PI_2P62 = 64'hC90FDAA22168C235;

  typedef struct packed {
    logic signed [32:0] trace;
    logic signed [31:0] xx;
    logic signed [31:0] xy;
  } root_side_t;

  typedef struct packed {
    logic [33:0]        smax;
    logic signed [32:0] trace;
    logic               xy_zero;
    logic               num_zero;
    logic               num_neg;
    logic               neg;
  } cordic_side_t;

  // atan(2^-i) in units of pi / 2^62
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] dvd;
    logic [63:0] den;
    logic [63:0] part;
    logic [63:0] rem;
    logic [63:0] q;
    logic        carry;
    int          sh;
    sum = '0;
    q   = '0;
    if (i == 0) begin
      return 64'd1 << 60;
    end
    for (int k = 0; k < 64; k++) begin
      sh = i * (2 * k + 1);
      if (sh < 64) begin
        dvd  = 64'd1 << (64 - sh);
        den  = 64'(2 * k + 1);
        part = '0;
        term = '0;
        for (int b = 63; b >= 0; b--) begin
          part = {part[62:0], dvd[b]};
          term = {term[62:0], 1'b0};
          if (part >= den) begin
            part = part - den;
            term[0] = 1'b1;
          end
        end
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    rem = sum;
    for (int s = 0; s < 60; s++) begin
      carry = rem[63];
      rem   = {rem[62:0], 1'b0};
      q     = {q[62:0], 1'b0};
      if (carry || rem >= PI_2P62) begin
        rem  = rem - PI_2P62;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

// File: rtl/psd_root_cell.sv
// one digit of the square root chain: decides one root bit and passes the rest on
module psd_root_cell #(
  parameter int ROOT_W = 34,
  parameter int REM_W  = 70,
  parameter int BIT    = 33
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_in,
  input  logic [REM_W-1:0]    rem_in,
  input  logic [ROOT_W-1:0]   root_in,
  input  psd_pkg::root_side_t side_in,
  output logic                valid_out,
  output logic [REM_W-1:0]    rem_out,
  output logic [ROOT_W-1:0]   root_out,
  output psd_pkg::root_side_t side_out
);

  logic                valid_r;
  logic [REM_W-1:0]    rem_r;
  logic [REM_W-1:0]    rem_nxt;
  logic [ROOT_W-1:0]   root_r;
  logic [ROOT_W-1:0]   root_nxt;
  psd_pkg::root_side_t side_r;
  logic [REM_W-1:0]    trial;

  assign trial = (REM_W'(root_in) << (BIT + 1)) | (REM_W'(1) << (2 * BIT));

  always_comb begin
    rem_nxt  = rem_in;
    root_nxt = root_in;
    if (rem_in >= trial) begin
      rem_nxt       = rem_in - trial;
      root_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign rem_out   = rem_r;
  assign root_out  = root_r;
  assign side_out  = side_r;

endmodule

// File: rtl/psd_cordic_cell.sv
// one vectoring step of the arctangent chain
module psd_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid_in,
  input  logic [63:0]           cx_in,
  input  logic [63:0]           cy_in,
  input  logic [63:0]           z_in,
  input  psd_pkg::cordic_side_t side_in,
  output logic                  valid_out,
  output logic [63:0]           cx_out,
  output logic [63:0]           cy_out,
  output logic [63:0]           z_out,
  output psd_pkg::cordic_side_t side_out
);

  localparam logic [63:0] ATAN = psd_pkg::atan_entry(STEP);

  logic                  valid_r;
  logic [63:0]           cx_r;
  logic [63:0]           cy_r;
  logic [63:0]           z_r;
  logic [63:0]           cx_nxt;
  logic [63:0]           cy_nxt;
  logic [63:0]           z_nxt;
  psd_pkg::cordic_side_t side_r;
  logic [63:0]           dx;
  logic [63:0]           dy;

  assign dx = 64'($signed(cy_in) >>> STEP);
  assign dy = 64'($signed(cx_in) >>> STEP);

  always_comb begin
    if (!cy_in[63]) begin
      cx_nxt = cx_in + dx;
      cy_nxt = cy_in - dy;
      z_nxt  = z_in + ATAN;
    end else begin
      cx_nxt = cx_in - dx;
      cy_nxt = cy_in + dy;
      z_nxt  = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      z_r    <= z_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign cx_out    = cx_r;
  assign cy_out    = cy_r;
  assign z_out     = z_r;
  assign side_out  = side_r;

endmodule

// File: rtl/principal_stress_direction.sv
// top level: principal stress and direction of one 2d stress tensor
// throughput: one tensor per cycle unless a stalled output holds the chain; 3 setup stages,
// one root cell per root bit, one post stage, 60 cordic cells and the output register
// a stalled output freezes the whole chain; reset clears all valid bits only
module principal_stress_direction #(
  parameter int ANGLE_FRAC_BITS = 15,
  parameter int ROOT_ITERATIONS = 34
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_stress_xx,
  input  logic signed [31:0] in_stress_xy,
  input  logic signed [31:0] in_stress_yy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [33:0] out_max_principal,
  output logic signed [32:0] out_stress_trace,
  output logic signed [15:0] out_direction,
  output logic               out_undefined_angle
);

  localparam int N     = ROOT_ITERATIONS;
  localparam int REM_W = (2 * N + 2 > psd_pkg::RAD_W) ? 2 * N + 2 : psd_pkg::RAD_W;
  localparam int SM_W  = ((N > 33) ? N : 33) + 2;
  localparam int NS    = psd_pkg::CORDIC_STEPS;
  localparam logic signed [63:0] HALF_PI = 64'sd1 <<< (ANGLE_FRAC_BITS - 1);

  logic pipe_en;
  assign pipe_en  = !(out_valid && out_stall);
  assign in_stall = !pipe_en;

  // setup stages
  logic                v0_r;
  logic                v1_r;
  logic                v2_r;
  logic [32:0]         ad_r;
  logic [31:0]         as_r;
  logic [65:0]         d2_r;
  logic [63:0]         s2_r;
  logic [REM_W-1:0]    rad_r;
  psd_pkg::root_side_t side0_r;
  psd_pkg::root_side_t side1_r;
  psd_pkg::root_side_t side2_r;
  logic signed [32:0]  diff;
  psd_pkg::root_side_t side0_nxt;

  assign diff = 33'(in_stress_xx) - 33'(in_stress_yy);

  always_comb begin
    side0_nxt.trace = 33'(in_stress_xx) + 33'(in_stress_yy);
    side0_nxt.xx    = in_stress_xx;
    side0_nxt.xy    = in_stress_xy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (pipe_en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ad_r    <= diff[32] ? 33'(-diff) : 33'(diff);
      as_r    <= in_stress_xy[31] ? 32'(-in_stress_xy) : 32'(in_stress_xy);
      side0_r <= side0_nxt;
      d2_r    <= 66'(ad_r) * 66'(ad_r);
      s2_r    <= 64'(as_r) * 64'(as_r);
      side1_r <= side0_r;
      rad_r   <= REM_W'(d2_r) + (REM_W'(s2_r) << 2);
      side2_r <= side1_r;
    end
  end

  // square root chain
  logic                rv    [N+1];
  logic [REM_W-1:0]    rrem  [N+1];
  logic [N-1:0]        rroot [N+1];
  psd_pkg::root_side_t rside [N+1];

  assign rv[0]    = v2_r;
  assign rrem[0]  = rad_r;
  assign rroot[0] = '0;
  assign rside[0] = side2_r;

  for (genvar i = 0; i < N; i++) begin : g_root
    psd_root_cell #(
      .ROOT_W(N),
      .REM_W (REM_W),
      .BIT   (N - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .valid_in (rv[i]),
      .rem_in   (rrem[i]),
      .root_in  (rroot[i]),
      .side_in  (rside[i]),
      .valid_out(rv[i+1]),
      .rem_out  (rrem[i+1]),
      .root_out (rroot[i+1]),
      .side_out (rside[i+1])
    );
  end

  // post stage: max principal, numerator, cordic start vector
  logic signed [SM_W-1:0] rsum;
  logic signed [SM_W-1:0] smax;
  logic signed [SM_W-1:0] num;
  logic [SM_W-1:0]        an;
  logic [31:0]            axy;
  psd_pkg::root_side_t    ps;
  psd_pkg::cordic_side_t  cs_nxt;
  logic                   v3_r;
  logic [63:0]            cx3_r;
  logic [63:0]            cy3_r;
  psd_pkg::cordic_side_t  cs3_r;

  assign ps   = rside[N];
  assign rsum = SM_W'(ps.trace) + $signed(SM_W'(rroot[N]));
  assign smax = rsum >>> 1;
  assign num  = smax - SM_W'(ps.xx);
  assign an   = num[SM_W-1] ? SM_W'(-num) : SM_W'(num);
  assign axy  = ps.xy[31] ? 32'(-ps.xy) : 32'(ps.xy);

  always_comb begin
    cs_nxt.smax     = 34'(64'(smax));
    cs_nxt.trace    = ps.trace;
    cs_nxt.xy_zero  = (ps.xy == '0);
    cs_nxt.num_zero = (num == '0);
    cs_nxt.num_neg  = num[SM_W-1];
    cs_nxt.neg      = num[SM_W-1] != ps.xy[31];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (pipe_en) begin
      v3_r <= rv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      cx3_r <= 64'(axy) << psd_pkg::CORDIC_PRESHIFT;
      cy3_r <= 64'(an) << psd_pkg::CORDIC_PRESHIFT;
      cs3_r <= cs_nxt;
    end
  end

  // cordic chain
  logic                  cv  [NS+1];
  logic [63:0]           ccx [NS+1];
  logic [63:0]           ccy [NS+1];
  logic [63:0]           cz  [NS+1];
  psd_pkg::cordic_side_t cside [NS+1];

  assign cv[0]    = v3_r;
  assign ccx[0]   = cx3_r;
  assign ccy[0]   = cy3_r;
  assign cz[0]    = '0;
  assign cside[0] = cs3_r;

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    psd_cordic_cell #(
      .STEP(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .valid_in (cv[i]),
      .cx_in    (ccx[i]),
      .cy_in    (ccy[i]),
      .z_in     (cz[i]),
      .side_in  (cside[i]),
      .valid_out(cv[i+1]),
      .cx_out   (ccx[i+1]),
      .cy_out   (ccy[i+1]),
      .z_out    (cz[i+1]),
      .side_out (cside[i+1])
    );
  end

  // rounding, clamp, sign and zero shear selection
  logic [63:0]           zr;
  logic signed [63:0]    kq;
  logic signed [63:0]    kc;
  logic signed [63:0]    dir;
  logic                  flag;
  psd_pkg::cordic_side_t fs;

  assign fs = cside[NS];
  assign zr = cz[NS] + (64'd1 << (61 - ANGLE_FRAC_BITS));
  assign kq = $signed(zr) >>> (62 - ANGLE_FRAC_BITS);

  always_comb begin
    kc   = kq;
    dir  = '0;
    flag = 1'b0;
    if (kq < 0) begin
      kc = '0;
    end else if (kq > HALF_PI) begin
      kc = HALF_PI;
    end
    if (fs.xy_zero) begin
      if (fs.num_zero) begin
        flag = 1'b1;
      end else if (fs.num_neg) begin
        dir = -HALF_PI;
      end else begin
        dir = HALF_PI;
      end
    end else begin
      dir = fs.neg ? -kc : kc;
    end
  end

  logic               out_valid_r;
  logic signed [33:0] max_r;
  logic signed [32:0] trace_r;
  logic signed [15:0] dir_r;
  logic               flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= cv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      max_r   <= fs.smax;
      trace_r <= fs.trace;
      dir_r   <= dir[15:0];
      flag_r  <= flag;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_max_principal   = max_r;
  assign out_stress_trace    = trace_r;
  assign out_direction       = dir_r;
  assign out_undefined_angle = flag_r;

  a_flag_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_undefined_angle |-> out_direction == '0)
    else $error("undefined angle with nonzero direction");

  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(rv[N]) && $stable(cv[NS]))
    else $error("chain moved while output stalled");

  a_front_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v0_r)
    else $error("input transfer lost at front stage");

endmodule

// File: verif/tb_top.sv
// testbench for principal_stress_direction: random and directed tensors vs a local predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ANGLE_BITS = 15;
  localparam int ROOT_BITS  = 34;
  localparam int NUM_RANDOM = 1900;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

  typedef struct {
    logic signed [31:0] xx;
    logic signed [31:0] xy;
    logic signed [31:0] yy;
  } tensor_t;

  typedef struct {
    logic signed [33:0] smax;
    logic signed [32:0] trace;
    logic signed [15:0] dir;
    logic               undef;
  } principal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_stress_xx = '0;
  logic signed [31:0] in_stress_xy = '0;
  logic signed [31:0] in_stress_yy = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [33:0] out_max_principal;
  logic signed [32:0] out_stress_trace;
  logic signed [15:0] out_direction;
  logic out_undefined_angle;

  tensor_t    pending_tensors[$];
  principal_t expected_results[$];
  logic [63:0] atan_q62[60];
  int  errors = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_mode = 0;
  int  stall_phase = 0;
  int  idle_cycles = 0;

  principal_stress_direction #(
    .ANGLE_FRAC_BITS(ANGLE_BITS),
    .ROOT_ITERATIONS(ROOT_BITS)
  ) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] atan_step_angle(int i);
    logic [63:0] acc;
    logic [63:0] rem;
    logic [63:0] q;
    logic        carry;
    int          sh;
    acc = '0;
    q = '0;
    if (i == 0) begin
      return 64'd1 << 60;
    end
    for (int k = 0; k < 64; k++) begin
      sh = i * (2 * k + 1);
      if (sh < 64) begin
        if (k % 2 == 1) begin
          acc = acc - (64'd1 << (64 - sh)) / 64'(2 * k + 1);
        end else begin
          acc = acc + (64'd1 << (64 - sh)) / 64'(2 * k + 1);
        end
      end
    end
    rem = acc;
    for (int s = 0; s < 60; s++) begin
      carry = rem[63];
      rem = rem << 1;
      q = q << 1;
      if (carry || rem >= PI_Q62) begin
        rem = rem - PI_Q62;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint vector_angle(logic [63:0] y, logic [63:0] x);
    logic [63:0] cx;
    logic [63:0] cy;
    logic [63:0] z;
    logic [63:0] dx;
    logic [63:0] dy;
    longint      k;
    cx = x << 26;
    cy = y << 26;
    z = '0;
    for (int i = 0; i < 60; i++) begin
      dx = $signed(cy) >>> i;
      dy = $signed(cx) >>> i;
      if (!cy[63]) begin
        cx = cx + dx;
        cy = cy - dy;
        z = z + atan_q62[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z = z - atan_q62[i];
      end
    end
    z = z + (64'd1 << (61 - ANGLE_BITS));
    k = $signed(z) >>> (62 - ANGLE_BITS);
    if (k < 0) k = 0;
    if (k > (longint'(1) << (ANGLE_BITS - 1))) k = longint'(1) << (ANGLE_BITS - 1);
    return k;
  endfunction

  function automatic principal_t principal_stress(tensor_t t);
    principal_t  r;
    longint      xx;
    longint      xy;
    longint      yy;
    longint      trace;
    longint      d;
    longint      smax;
    longint      num;
    longint      dir;
    logic [63:0] ad;
    logic [63:0] as;
    logic [67:0] radicand;
    logic [67:0] cand;
    logic [67:0] root;
    xx = t.xx;
    xy = t.xy;
    yy = t.yy;
    trace = xx + yy;
    d = xx - yy;
    ad = d < 0 ? -d : d;
    as = xy < 0 ? -xy : xy;
    radicand = (68'(as * as) << 2) + 68'(ad * ad);
    root = '0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      cand = root | (68'd1 << b);
      if (cand * cand <= radicand) root = cand;
    end
    smax = (trace + longint'(root)) >>> 1;
    num = smax - xx;
    r.undef = 1'b0;
    if (xy == 0) begin
      if (num > 0) dir = longint'(1) << (ANGLE_BITS - 1);
      else if (num < 0) dir = -(longint'(1) << (ANGLE_BITS - 1));
      else begin
        dir = 0;
        r.undef = 1'b1;
      end
    end else begin
      dir = vector_angle(num < 0 ? -num : num, as);
      if ((num < 0) != (xy < 0)) dir = -dir;
    end
    r.smax = smax[33:0];
    r.trace = trace[32:0];
    r.dir = dir[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rand_stress(int kind);
    case (kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff - $urandom_range(0, 3)
                                           : 32'sh8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic add_tensor(logic signed [31:0] xx, logic signed [31:0] xy,
                            logic signed [31:0] yy);
    tensor_t t;
    t.xx = xx;
    t.xy = xy;
    t.yy = yy;
    pending_tensors.push_back(t);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0 || pending_tensors.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        tensor_t t;
        t = pending_tensors.pop_front();
        in_valid <= 1'b1;
        in_stress_xx <= t.xx;
        in_stress_xy <= t.xy;
        in_stress_yy <= t.yy;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (stall_phase == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_phase <= $urandom_range(20, 200);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 9) < 3;
      2: out_stall <= $urandom_range(0, 9) < 7;
      default: out_stall <= (stall_phase % 8) < 3;
    endcase
  end

  // monitor
  always @(posedge clk) begin
    tensor_t    t;
    principal_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        t.xx = in_stress_xx;
        t.xy = in_stress_xy;
        t.yy = in_stress_yy;
        expected_results.push_back(principal_stress(t));
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_max_principal !== e.smax) begin
            $error("max_principal expected %0d actual %0d", e.smax, out_max_principal);
            errors++;
          end
          if (out_stress_trace !== e.trace) begin
            $error("stress_trace expected %0d actual %0d", e.trace, out_stress_trace);
            errors++;
          end
          if (out_direction !== e.dir) begin
            $error("direction expected %0d actual %0d", e.dir, out_direction);
            errors++;
          end
          if (out_undefined_angle !== e.undef) begin
            $error("undefined_angle expected %0d actual %0d", e.undef, out_undefined_angle);
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    for (int i = 0; i < 60; i++) atan_q62[i] = atan_step_angle(i);
    // directed: extremes, zero shear both signs, isotropic, ties of sign
    add_tensor(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    add_tensor(32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_tensor(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    add_tensor(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    add_tensor(32'sh80000000, 0, 32'sh7fffffff);
    add_tensor(32'sh7fffffff, 0, 32'sh80000000);
    add_tensor(0, 0, 0);
    add_tensor(32'sh00010000, 0, 32'sh00010000);
    add_tensor(32'sh80000000, 0, 32'sh80000000);
    add_tensor(0, 0, 32'sh00010000);
    add_tensor(32'sh00010000, 0, 0);
    add_tensor(0, 32'sh00010000, 0);
    add_tensor(0, -32'sh00010000, 0);
    add_tensor(1, 1, 1);
    add_tensor(-1, -1, -1);
    add_tensor(32'sh00030000, 32'sh00020000, -32'sh00010000);
    add_tensor(-32'sh00030000, -32'sh00020000, 32'sh00010000);
    add_tensor(32'sh7fffffff, 1, 32'sh80000000);
    add_tensor(32'sh80000000, -1, 32'sh7fffffff);
    add_tensor(32'sh55555555, 32'shaaaaaaaa, 32'sh33333333);
    add_tensor(32'shaaaaaaaa, 32'sh55555555, 32'shcccccccc);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      kind = $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0: add_tensor(rand_stress(kind), 0, rand_stress(kind));
        1: begin
          logic signed [31:0] v;
          v = rand_stress(kind);
          add_tensor(v, $urandom_range(0, 1) ? 0 : rand_stress(kind), v);
        end
        default: add_tensor(rand_stress(kind), rand_stress($urandom_range(0, 3)),
                            rand_stress(kind));
      endcase
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_tensors.size() == 0);
    @(posedge clk);
    while (in_valid && in_stall) @(posedge clk);
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
